[design/dpit_pkg.sv]
// Shared types, register codes and reset values for the debounced press interval timer.
// No dependencies.

package dpit_pkg;

	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_TOP   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TOP = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STABLE_COUNT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_LIMIT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_LIMIT   = 3'd4;

	localparam logic [15:0] RST_PERIOD_TOP   = 16'd9999;
	localparam logic [15:0] RST_DEBOUNCE_TOP = 16'd1000;
	localparam logic [3:0]  RST_STABLE_COUNT = 4'd10;
	localparam logic [15:0] RST_SHORT_LIMIT  = 16'd50;
	localparam logic [15:0] RST_LONG_LIMIT   = 16'd100;

	localparam logic [3:0]  RUN_MAX  = 4'hF;
	localparam logic [15:0] WRAP_MAX = 16'hFFFF;

	typedef struct packed {
		logic [15:0] period_top;
		logic [15:0] debounce_top;
		logic [3:0]  stable_count;
		logic [15:0] short_limit;
		logic [15:0] long_limit;
	} cfg_t;

	typedef struct packed {
		logic        led_red;
		logic        led_green;
		logic [15:0] interval_units;
		logic        measure_done;
		logic        press_seen;
	} res_t;

endpackage

[design/debounced_press_interval_timer.sv]
// Top level: configuration registers, input register, result register and assertions.
// Depends on dpit_pkg, dpit_debounce and dpit_measure.
//
//  channel | signals                                   | transfer when
//  --------+-------------------------------------------+-----------------------
//  in      | in_valid, in_ready, switch_level          | in_valid & in_ready
//  out     | out_valid, out_ready, led_red, led_green, | out_valid & out_ready
//          | interval_units, measure_done, press_seen  |
//  cfg     | cfg_write, cfg_index, cfg_data            | cfg_write
//
// One item per cycle sustained while the output is not stalled; a result passes through
// the input register and then the result register before it is presented.
// The path is one input register plus one result register around single-pass state update.
// A stalled output holds the result register; the input register refills as results drain.
// Reset restores the register defaults and resets all timer and debounce state.

module debounced_press_interval_timer (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               switch_level,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               led_red,
	output logic                               led_green,
	output logic [15:0]                        interval_units,
	output logic                               measure_done,
	output logic                               press_seen,
	input  logic                               cfg_write,
	input  logic [dpit_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dpit_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import dpit_pkg::*;

	cfg_t cfg_q;
	logic valid_s1;
	logic level_s1;
	logic out_valid_q;
	res_t res_q;
	res_t res_c;
	logic advance;
	logic pressed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.period_top   <= RST_PERIOD_TOP;
			cfg_q.debounce_top <= RST_DEBOUNCE_TOP;
			cfg_q.stable_count <= RST_STABLE_COUNT;
			cfg_q.short_limit  <= RST_SHORT_LIMIT;
			cfg_q.long_limit   <= RST_LONG_LIMIT;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_PERIOD_TOP:   cfg_q.period_top   <= cfg_data;
				CFG_DEBOUNCE_TOP: cfg_q.debounce_top <= cfg_data;
				CFG_STABLE_COUNT: cfg_q.stable_count <= cfg_data[3:0];
				CFG_SHORT_LIMIT:  cfg_q.short_limit  <= cfg_data;
				CFG_LONG_LIMIT:   cfg_q.long_limit   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			level_s1 <= switch_level;
		end
	end

	dpit_debounce u_debounce (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.level   (level_s1),
		.cfg     (cfg_q),
		.pressed (pressed)
	);

	dpit_measure u_measure (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.pressed (pressed),
		.cfg     (cfg_q),
		.res     (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_c;
		end
	end

	assign out_valid      = out_valid_q;
	assign led_red        = res_q.led_red;
	assign led_green      = res_q.led_green;
	assign interval_units = res_q.interval_units;
	assign measure_done   = res_q.measure_done;
	assign press_seen     = res_q.press_seen;

`ifndef SYNTHESIS
	a_done_needs_press: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!res_q.measure_done || res_q.press_seen))
		else $error("measure_done without press_seen");

	a_led_lit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (res_q.led_red || res_q.led_green))
		else $error("no LED lit on a valid result");

	a_advance_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("result register not loaded after advance");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !out_ready) |-> !in_ready)
		else $error("input taken while pipeline is stalled and full");
`endif

endmodule

[design/dpit_debounce.sv]
// Edge-armed switch debouncer with sampling divider and stable-run counter.
// Depends on dpit_pkg.

module dpit_debounce (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic          level,
	input  dpit_pkg::cfg_t cfg,
	output logic          pressed
);
	import dpit_pkg::*;

	logic        active_q, active_n;
	logic [15:0] div_q, div_n;
	logic        stab_q, stab_n;
	logic [3:0]  run_q, run_n;
	logic        prev_q;

	always_comb begin
		active_n = active_q;
		div_n    = div_q;
		stab_n   = stab_q;
		run_n    = run_q;
		pressed  = 1'b0;
		if (!active_q) begin
			if (prev_q && !level) begin
				active_n = 1'b1;
				div_n    = '0;
				run_n    = '0;
				stab_n   = level;
			end
		end else if (div_q >= cfg.debounce_top) begin
			div_n = '0;
			if (level == stab_q) begin
				if (run_q != RUN_MAX) begin
					run_n = run_q + 4'd1;
				end
			end else begin
				run_n  = '0;
				stab_n = level;
			end
			if (run_n >= cfg.stable_count) begin
				active_n = 1'b0;
				pressed  = !stab_n;
			end
		end else begin
			div_n = div_q + 16'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			div_q    <= '0;
			stab_q   <= 1'b0;
			run_q    <= '0;
			prev_q   <= 1'b1;
		end else if (step) begin
			active_q <= active_n;
			div_q    <= div_n;
			stab_q   <= stab_n;
			run_q    <= run_n;
			prev_q   <= level;
		end
	end

endmodule

[design/dpit_measure.sv]
// Wrapping period counter, press capture, interval computation and LED classing.
// Depends on dpit_pkg.

module dpit_measure (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic           pressed,
	input  dpit_pkg::cfg_t cfg,
	output dpit_pkg::res_t res
);
	import dpit_pkg::*;

	logic [15:0] ctr_q, ctr_n;
	logic [15:0] wraps_q, wraps_n, wraps_p;
	logic [15:0] first_q, first_n;
	logic        await_q, await_p;
	logic [15:0] last_q, last_n;
	logic        done;
	logic        below_short, below_long;

	always_comb begin
		first_n = first_q;
		last_n  = last_q;
		await_p = await_q;
		wraps_p = wraps_q;
		done    = 1'b0;
		if (pressed) begin
			if (!await_q) begin
				first_n = ctr_q;
				wraps_p = '0;
				await_p = 1'b1;
			end else begin
				if (ctr_q < first_q && wraps_q != '0) begin
					last_n = wraps_q - 16'd1;
				end else begin
					last_n = wraps_q;
				end
				await_p = 1'b0;
				done    = 1'b1;
			end
		end
		if (ctr_q >= cfg.period_top) begin
			ctr_n = '0;
			if (await_p && wraps_p != WRAP_MAX) begin
				wraps_n = wraps_p + 16'd1;
			end else begin
				wraps_n = wraps_p;
			end
		end else begin
			ctr_n   = ctr_q + 16'd1;
			wraps_n = wraps_p;
		end
		below_short = last_n < cfg.short_limit;
		below_long  = last_n < cfg.long_limit;
		res.led_red        = below_short || !below_long;
		res.led_green      = !below_short;
		res.interval_units = last_n;
		res.measure_done   = done;
		res.press_seen     = pressed;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q   <= '0;
			wraps_q <= '0;
			first_q <= '0;
			await_q <= 1'b0;
			last_q  <= '0;
		end else if (step) begin
			ctr_q   <= ctr_n;
			wraps_q <= wraps_n;
			first_q <= first_n;
			await_q <= await_p;
			last_q  <= last_n;
		end
	end

endmodule
